// ===== design/mco_pkg.sv =====
// mco_pkg: shared types, sizes and the reset cursor shape for the cursor overlay
// no dependencies; imported by mouse_cursor_overlay
`timescale 1ns / 1ps

package mco_pkg;

   localparam int CURSOR_SIZE = 16;
   localparam int COORD_BITS  = 12;
   localparam int ROW_BITS    = $clog2(CURSOR_SIZE);
   // window offsets need two bits beyond a coordinate: difference plus hotspot
   localparam int WIN_BITS    = COORD_BITS + 2;
   localparam int HOT_BITS    = 4;
   localparam int COLOR_BITS  = 8;
   localparam int SLOT_BITS   = 5;

   localparam logic [COLOR_BITS-1:0] COLOR_WHITE = 8'd15;
   localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 8'd0;

   localparam logic signed [7:0] LEVEL_SHOWN  = 8'sd0;
   localparam logic signed [7:0] LEVEL_HIDDEN = -8'sd1;
   localparam logic signed [7:0] LEVEL_MIN    = -8'sd128;

   typedef enum logic [2:0] {
      KIND_PIXEL = 3'd0,
      KIND_MOVE  = 3'd1,
      KIND_SHOW  = 3'd2,
      KIND_HIDE  = 3'd3,
      KIND_LOAD  = 3'd4,
      KIND_RECT  = 3'd5
   } kind_type;

   typedef enum logic {
      CSR_HOTSPOT_X = 1'b0,
      CSR_HOTSPOT_Y = 1'b1
   } csr_index_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [CURSOR_SIZE-1:0]       mask_row_type;

   // arrow shape, screen (and) rows
   localparam mask_row_type SCREEN_ARROW [CURSOR_SIZE] = '{
      16'h9FFF, 16'h8FFF, 16'h87FF, 16'h83FF, 16'h81FF, 16'h80FF, 16'h807F, 16'h803F,
      16'h801F, 16'h800F, 16'h80FF, 16'h887F, 16'h987F, 16'hFC3F, 16'hFC3F, 16'hFE3F
   };

   // arrow shape, cursor (xor) rows
   localparam mask_row_type CURSOR_ARROW [CURSOR_SIZE] = '{
      16'h0000, 16'h2000, 16'h3000, 16'h3800, 16'h3C00, 16'h3E00, 16'h3F00, 16'h3F80,
      16'h3FC0, 16'h3E00, 16'h3600, 16'h2300, 16'h0300, 16'h0180, 16'h0180, 16'h0000
   };

endpackage

// ===== design/mouse_cursor_overlay.sv =====
// mouse_cursor_overlay: 16x16 and/xor mask pointer overlay on a pixel stream
// depends on mco_pkg
`timescale 1ns / 1ps

// One item is taken per clock and passes through an input register, one level
// of compositing logic and a result register, so pixels stream at one per cycle
// while rsp_tready does not hold back the result register; rsp valid rises
// as a pixel moves from the input register into the result register. Control
// items (move, show, hide, mask load, exclusion rectangle) update state as
// they leave the input register and give no rsp transfer; the next item
// already sees the new state. The cursor shape store starts as the arrow and
// is held in flops, so it is usable right after reset. The user must set the
// hotspot via the csr port only while the stream is idle; not enforced here.
module mouse_cursor_overlay (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // coord_x, coord_y, far_x, far_y, background, mask_slot, mask_bits, zero pad
   input  logic [79:0]            req_tdata,
   // kind
   input  mco_pkg::kind_type      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pixel_out
   output logic [7:0]             rsp_tdata,
   // cursor_hit, cursor_shown
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_we,
   input  mco_pkg::csr_index_type csr_index,
   input  logic [3:0]             csr_wdata
);
   import mco_pkg::*;

   // input register
   logic                  in_valid_ff;
   kind_type              kind_ff;
   coord_type             coord_x_ff, coord_y_ff, far_x_ff, far_y_ff;
   logic [COLOR_BITS-1:0] background_ff;
   logic [SLOT_BITS-1:0]  mask_slot_ff;
   mask_row_type          mask_bits_ff;

   // block state
   mask_row_type          screen_ff [CURSOR_SIZE];
   mask_row_type          cursor_ff [CURSOR_SIZE];
   logic signed [7:0]     level_ff, level_in;
   coord_type             pointer_x_ff, pointer_y_ff, pointer_x_in, pointer_y_in;
   coord_type             rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;
   coord_type             rect_left_in, rect_top_in, rect_right_in, rect_bottom_in;
   logic [HOT_BITS-1:0]   hotspot_x_ff, hotspot_y_ff;

   // result register
   logic                  out_valid_ff;
   logic [COLOR_BITS-1:0] pixel_ff, pixel_in;
   logic                  hit_ff, hit_in;
   logic                  shown_ff;

   logic                  out_free, retire, is_pixel, shown;
   logic signed [WIN_BITS-1:0] col, row;
   logic [ROW_BITS-1:0]   row_idx, bit_idx;
   logic                  scr_bit, cur_bit, in_rect;

   assign is_pixel   = (kind_ff == KIND_PIXEL);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign retire     = in_valid_ff && (!is_pixel || out_free);
   assign req_tready = !in_valid_ff || retire;
   assign shown      = (level_ff == LEVEL_SHOWN);

   // compositing
   always_comb begin
      col = WIN_BITS'(coord_x_ff) - WIN_BITS'(pointer_x_ff)
          + $signed(WIN_BITS'(hotspot_x_ff));
      row = WIN_BITS'(coord_y_ff) - WIN_BITS'(pointer_y_ff)
          + $signed(WIN_BITS'(hotspot_y_ff));
      row_idx = row[ROW_BITS-1:0];
      // msb of a row word is the leftmost column
      bit_idx = ROW_BITS'(CURSOR_SIZE - 1) - col[ROW_BITS-1:0];
      scr_bit = screen_ff[row_idx][bit_idx];
      cur_bit = cursor_ff[row_idx][bit_idx];
      hit_in  = shown && (col[WIN_BITS-1:ROW_BITS] == '0)
                      && (row[WIN_BITS-1:ROW_BITS] == '0);
      pixel_in = background_ff;
      if (hit_in) begin
         if (!scr_bit) begin
            pixel_in = cur_bit ? COLOR_WHITE : COLOR_BLACK;
         end else if (cur_bit) begin
            pixel_in = background_ff ^ COLOR_WHITE;
         end
      end
   end

   // control item state updates
   always_comb begin
      level_in       = level_ff;
      pointer_x_in   = pointer_x_ff;
      pointer_y_in   = pointer_y_ff;
      rect_left_in   = rect_left_ff;
      rect_top_in    = rect_top_ff;
      rect_right_in  = rect_right_ff;
      rect_bottom_in = rect_bottom_ff;
      in_rect = (coord_x_ff >= rect_left_ff) && (coord_x_ff <= rect_right_ff)
             && (coord_y_ff >= rect_top_ff)  && (coord_y_ff <= rect_bottom_ff);
      if (retire) begin
         unique case (kind_ff)
            KIND_MOVE: begin
               pointer_x_in = coord_x_ff;
               pointer_y_in = coord_y_ff;
               if (shown && in_rect) level_in = LEVEL_HIDDEN;
            end
            KIND_SHOW: begin
               if (level_ff != LEVEL_SHOWN) begin
                  if (level_ff == LEVEL_HIDDEN) begin
                     rect_left_in   = '1;
                     rect_top_in    = '1;
                     rect_right_in  = '1;
                     rect_bottom_in = '1;
                  end
                  level_in = level_ff + 8'sd1;
               end
            end
            KIND_HIDE: begin
               if (level_ff != LEVEL_MIN) level_in = level_ff - 8'sd1;
            end
            KIND_RECT: begin
               rect_left_in   = coord_x_ff;
               rect_top_in    = coord_y_ff;
               rect_right_in  = far_x_ff;
               rect_bottom_in = far_y_ff;
            end
            default: begin
               // pixels, mask loads and unused kinds leave these alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff       <= req_tuser;
         coord_x_ff    <= req_tdata[11:0];
         coord_y_ff    <= req_tdata[23:12];
         far_x_ff      <= req_tdata[35:24];
         far_y_ff      <= req_tdata[47:36];
         background_ff <= req_tdata[55:48];
         mask_slot_ff  <= req_tdata[60:56];
         mask_bits_ff  <= req_tdata[76:61];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= LEVEL_HIDDEN;
         pointer_x_ff   <= '0;
         pointer_y_ff   <= '0;
         rect_left_ff   <= '1;
         rect_top_ff    <= '1;
         rect_right_ff  <= '1;
         rect_bottom_ff <= '1;
      end else begin
         level_ff       <= level_in;
         pointer_x_ff   <= pointer_x_in;
         pointer_y_ff   <= pointer_y_in;
         rect_left_ff   <= rect_left_in;
         rect_top_ff    <= rect_top_in;
         rect_right_ff  <= rect_right_in;
         rect_bottom_ff <= rect_bottom_in;
      end
   end

   // shape store, reset to the arrow
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff <= SCREEN_ARROW;
         cursor_ff <= CURSOR_ARROW;
      end else if (retire && kind_ff == KIND_LOAD) begin
         if (mask_slot_ff[SLOT_BITS-1]) begin
            cursor_ff[mask_slot_ff[ROW_BITS-1:0]] <= mask_bits_ff;
         end else begin
            screen_ff[mask_slot_ff[ROW_BITS-1:0]] <= mask_bits_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hotspot_x_ff <= '0;
         hotspot_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOTSPOT_X: hotspot_x_ff <= csr_wdata;
            CSR_HOTSPOT_Y: hotspot_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= retire && is_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && retire && is_pixel) begin
         pixel_ff <= pixel_in;
         hit_ff   <= hit_in;
         shown_ff <= shown;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pixel_ff;
   assign rsp_tuser  = {shown_ff, hit_ff};

endmodule
